/* sv/union_find_weighted_halving_core_defines.svh */
// assertion macros for the disjoint-set core
// expects aclk and aresetn in the scope of each use
`ifndef UNION_FIND_WEIGHTED_HALVING_CORE_DEFINES_SVH
`define UNION_FIND_WEIGHTED_HALVING_CORE_DEFINES_SVH

// same-cycle implication
`define UFWH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UFWH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ufwh_pkg.sv */
// constants, types and helpers for the disjoint-set core
// no dependencies; used by every module of the block except ufwh_ram
package ufwh_pkg;

    localparam int ELEMENT_COUNT = 1024;
    localparam int ELEM_W        = 10;
    localparam int SIZE_W        = 11;
    localparam int IDX_W         = $clog2(ELEMENT_COUNT);
    localparam int HOP_W         = $clog2(ELEMENT_COUNT + 1);
    localparam int OPD_W         = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;

    localparam logic [1:0] OP_UNION = 2'd0;
    localparam logic [1:0] OP_FIND  = 2'd1;
    localparam logic [1:0] OP_CONN  = 2'd2;
    localparam logic [1:0] OP_SIZE  = 2'd3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [SIZE_W-1:0] tsize_t;
    typedef logic [OPD_W-1:0]  opd_t;

    typedef struct packed {
        logic we;
        idx_t waddr;
        idx_t wdata;
        idx_t raddr;
    } link_port_t;

    typedef struct packed {
        logic   we;
        idx_t   waddr;
        tsize_t wdata;
        idx_t   raddr;
    } size_port_t;

    typedef struct packed {
        logic eq;
        logic lt;
        opd_t sum;
    } alu_res_t;

    typedef struct packed {
        logic [ELEM_W-1:0] root;
        logic              same_set;
        tsize_t            set_size;
        logic              index_error;
    } res_t;

    // out-of-range links read as element zero
    function automatic idx_t clamp_idx(input idx_t x);
        return (32'(x) < ELEMENT_COUNT) ? x : '0;
    endfunction

    function automatic logic in_range(input logic [ELEM_W-1:0] x);
        return 32'(x) < ELEMENT_COUNT;
    endfunction

endpackage

/* sv/ufwh_ram.sv */
// generic single-write, single-read memory with registered read data
// read-first on a same-address write; no dependencies
module ufwh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/ufwh_alu.sv */
// shared compare and add unit of the disjoint-set core
// depends on ufwh_pkg
module ufwh_alu
    import ufwh_pkg::*;
(
    input  opd_t     opd_x,
    input  opd_t     opd_y,
    output alu_res_t res
);

    always_comb begin
        res.eq  = (opd_x == opd_y);
        res.lt  = (opd_x < opd_y);
        res.sum = opd_x + opd_y;
    end

endmodule

/* sv/ufwh_seq.sv */
// request sequencer: clearing pass, root walks with path halving, weighted link
// depends on ufwh_pkg, ufwh_alu and the assertion macro header
`include "union_find_weighted_halving_core_defines.svh"

module ufwh_seq
    import ufwh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_op,
    input  logic [ELEM_W-1:0] in_a,
    input  logic [ELEM_W-1:0] in_b,
    input  logic              out_free,
    output logic              res_valid,
    output res_t              res,
    output link_port_t        link_port,
    input  idx_t              link_rdata,
    output size_port_t        size_port,
    input  tsize_t            size_rdata
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_UP       = 4'd2;
    localparam logic [3:0] ST_GRAND    = 4'd3;
    localparam logic [3:0] ST_ROOTS    = 4'd4;
    localparam logic [3:0] ST_SZ_A     = 4'd5;
    localparam logic [3:0] ST_SZ_B     = 4'd6;
    localparam logic [3:0] ST_SZ_FINAL = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0]       state_reg, state_next;
    idx_t             clr_reg, clr_next;
    logic [1:0]       op_reg, op_next;
    idx_t             a_reg, a_next;
    idx_t             b_reg, b_next;
    idx_t             node_reg, node_next;
    logic [HOP_W-1:0] hops_reg, hops_next;
    logic             walk_reg, walk_next;
    idx_t             ra_reg, ra_next;
    idx_t             rb_reg, rb_next;
    tsize_t           sza_reg, sza_next;
    res_t             res_reg, res_next;

    opd_t     alu_x;
    opd_t     alu_y;
    alu_res_t alu_res;
    idx_t     link_data;
    idx_t     start_idx;
    idx_t     start2_idx;
    logic     in_uses_b;
    logic     reg_uses_b;
    tsize_t   size_sum;

    ufwh_alu u_alu (
        .opd_x (alu_x),
        .opd_y (alu_y),
        .res   (alu_res)
    );

    assign link_data  = clamp_idx(link_rdata);
    assign in_uses_b  = (in_op == OP_UNION) || (in_op == OP_CONN);
    assign reg_uses_b = (op_reg == OP_UNION) || (op_reg == OP_CONN);
    assign start_idx  = (in_op == OP_UNION) ? IDX_W'(in_b) : IDX_W'(in_a);
    assign start2_idx = (op_reg == OP_UNION) ? a_reg : b_reg;
    assign size_sum   = SIZE_W'(alu_res.sum);
    assign res        = res_reg;

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        node_next  = node_reg;
        hops_next  = hops_reg;
        walk_next  = walk_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        sza_next   = sza_reg;
        res_next   = res_reg;
        link_port  = '0;
        size_port  = '0;
        alu_x      = '0;
        alu_y      = '0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                link_port.we    = 1'b1;
                link_port.waddr = clr_reg;
                link_port.wdata = clr_reg;
                size_port.we    = 1'b1;
                size_port.waddr = clr_reg;
                size_port.wdata = SIZE_W'(1);
                if (clr_reg == IDX_W'(ELEMENT_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next = in_op;
                    a_next  = IDX_W'(in_a);
                    b_next  = IDX_W'(in_b);
                    if (!in_range(in_a) || (in_uses_b && !in_range(in_b))) begin
                        res_next.root        = '0;
                        res_next.same_set    = 1'b0;
                        res_next.set_size    = '0;
                        res_next.index_error = 1'b1;
                        state_next           = ST_DONE;
                    end else begin
                        res_next.same_set    = 1'b0;
                        res_next.index_error = 1'b0;
                        node_next            = start_idx;
                        hops_next            = '0;
                        walk_next            = 1'b0;
                        link_port.raddr      = start_idx;
                        state_next           = ST_UP;
                    end
                end
            end
            ST_UP: begin
                alu_x = OPD_W'(link_data);
                alu_y = OPD_W'(node_reg);
                if (alu_res.eq || (hops_reg == HOP_W'(ELEMENT_COUNT))) begin
                    // union walks b first, the other ops walk a first
                    if ((op_reg == OP_UNION) != walk_reg) begin
                        rb_next = node_reg;
                    end else begin
                        ra_next = node_reg;
                    end
                    if (!walk_reg && reg_uses_b) begin
                        node_next       = start2_idx;
                        hops_next       = '0;
                        walk_next       = 1'b1;
                        link_port.raddr = start2_idx;
                    end else if (reg_uses_b) begin
                        state_next = ST_ROOTS;
                    end else begin
                        size_port.raddr = node_reg;
                        res_next.root   = ELEM_W'(node_reg);
                        state_next      = ST_SZ_FINAL;
                    end
                end else begin
                    link_port.raddr = link_data;
                    state_next      = ST_GRAND;
                end
            end
            ST_GRAND: begin
                // path halving: point the node at its grandparent and jump there
                link_port.we    = 1'b1;
                link_port.waddr = node_reg;
                link_port.wdata = link_data;
                link_port.raddr = link_data;
                node_next       = link_data;
                hops_next       = hops_reg + 1'b1;
                state_next      = ST_UP;
            end
            ST_ROOTS: begin
                alu_x           = OPD_W'(ra_reg);
                alu_y           = OPD_W'(rb_reg);
                res_next.root   = ELEM_W'(ra_reg);
                size_port.raddr = ra_reg;
                if ((op_reg == OP_UNION) && !alu_res.eq) begin
                    state_next = ST_SZ_A;
                end else begin
                    res_next.same_set = alu_res.eq;
                    state_next        = ST_SZ_FINAL;
                end
            end
            ST_SZ_A: begin
                sza_next        = size_rdata;
                size_port.raddr = rb_reg;
                state_next      = ST_SZ_B;
            end
            ST_SZ_B: begin
                alu_x           = OPD_W'(size_rdata);
                alu_y           = OPD_W'(sza_reg);
                link_port.we    = 1'b1;
                size_port.we    = 1'b1;
                size_port.wdata = size_sum;
                if (alu_res.lt) begin
                    link_port.waddr = rb_reg;
                    link_port.wdata = ra_reg;
                    size_port.waddr = ra_reg;
                    res_next.root   = ELEM_W'(ra_reg);
                end else begin
                    link_port.waddr = ra_reg;
                    link_port.wdata = rb_reg;
                    size_port.waddr = rb_reg;
                    res_next.root   = ELEM_W'(rb_reg);
                end
                res_next.set_size = size_sum;
                state_next        = ST_DONE;
            end
            ST_SZ_FINAL: begin
                res_next.set_size = size_rdata;
                state_next        = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            hops_reg  <= '0;
            walk_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hops_reg  <= hops_next;
            walk_reg  <= walk_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        node_reg <= node_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        sza_reg  <= sza_next;
        res_reg  <= res_next;
    end

    `UFWH_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, state_reg != ST_IDLE, "ready after accepting an item")
    `UFWH_ASSERT_IMP(a_hops_bounded, state_reg == ST_UP || state_reg == ST_GRAND, hops_reg <= HOP_W'(ELEMENT_COUNT), "walk ran past the hop limit")
    `UFWH_ASSERT_IMP(a_no_write_at_rest, state_reg == ST_IDLE || state_reg == ST_DONE, !link_port.we && !size_port.we, "table written while no item is in work")
    `UFWH_ASSERT_NXT(a_idle_after_result, res_valid, state_reg == ST_IDLE, "sequencer not idle after delivering a result")
    `UFWH_ASSERT_IMP(a_error_result_zero, res_valid && res.index_error, res.root == '0 && !res.same_set && res.set_size == '0, "index error result carries data")

endmodule

/* sv/union_find_weighted_halving_core.sv */
// top level of the disjoint-set core: link and size memories, sequencer, output register
// depends on ufwh_pkg, ufwh_ram and ufwh_seq
//
// One item at a time: s_ready is high only while the sequencer is idle, and a finished
// result waits in the output register so the next item can be taken meanwhile. A find or
// size request on an element that is its own root passes through ST_UP, ST_SZ_FINAL and
// ST_DONE before m_valid rises. Every parent hop of a walk adds ST_UP and ST_GRAND, since
// the single read port of the link memory fetches the parent and then the grandparent.
// Connected adds a second walk and ST_ROOTS. Union adds a second walk and takes ST_ROOTS,
// ST_SZ_A and ST_SZ_B in place of ST_SZ_FINAL when it links two sets (two size reads,
// then the link write), or adds ST_ROOTS when both elements are already joined.
// After reset s_ready is low while a clearing pass loads both ELEMENT_COUNT (1024) tables.
module union_find_weighted_halving_core
    import ufwh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic [ELEM_W-1:0] s_elem_a,
    input  logic [ELEM_W-1:0] s_elem_b,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ELEM_W-1:0] m_root,
    output logic              m_same_set,
    output logic [SIZE_W-1:0] m_set_size,
    output logic              m_index_error
);

    link_port_t link_port;
    size_port_t size_port;
    idx_t       link_rdata;
    tsize_t     size_rdata;
    logic       res_valid;
    res_t       res;
    logic       out_free;

    logic m_valid_reg, m_valid_next;
    res_t out_reg, out_next;

    ufwh_ram #(
        .WIDTH (IDX_W),
        .DEPTH (ELEMENT_COUNT)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_port.we),
        .waddr (link_port.waddr),
        .wdata (link_port.wdata),
        .raddr (link_port.raddr),
        .rdata (link_rdata)
    );

    ufwh_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (ELEMENT_COUNT)
    ) u_size_ram (
        .aclk  (aclk),
        .we    (size_port.we),
        .waddr (size_port.waddr),
        .wdata (size_port.wdata),
        .raddr (size_port.raddr),
        .rdata (size_rdata)
    );

    ufwh_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_op      (s_op),
        .in_a       (s_elem_a),
        .in_b       (s_elem_b),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .link_port  (link_port),
        .link_rdata (link_rdata),
        .size_port  (size_port),
        .size_rdata (size_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_root        = out_reg.root;
    assign m_same_set    = out_reg.same_set;
    assign m_set_size    = out_reg.set_size;
    assign m_index_error = out_reg.index_error;

endmodule
